/* rtl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg: shared types and codes for the pinned slot cache table
// Command and status codes, field widths, and the records that move between
// the front end, the command queue and the execution back end.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 4;
  localparam int HANDLE_W = 32;
  localparam int HIT_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;   // width of cells_in_use and of active counts
  localparam int QDEPTH   = 2;   // command queue entries, a power of two

  localparam logic [CNT_W-1:0] CFG_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Classified command as it waits in the queue
  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [IDX_W-1:0]    cell_index;
    logic [CNT_W-1:0]    start;      // scan start, already reduced mod active
    logic [HANDLE_W-1:0] handle;
    logic [CNT_W-1:0]    active;     // active cell count, 1 .. cell limit
    logic                idx_ok;     // cell_index below the active count
  } psc_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    chosen_cell;
    logic [HANDLE_W-1:0] handle_out;
    logic                evicted_valid;
    logic [HIT_W-1:0]    hit_count;
  } psc_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } psc_q_stat_t;

endpackage

/* rtl/psc_in_if.sv */
// ----------------------------------------------------------------------------
// psc_in_if: command channel
// Valid/ready channel that carries one cache command per transfer.
// ----------------------------------------------------------------------------
interface psc_in_if;
  import psc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [IDX_W-1:0]    cell_index;
  logic [IDX_W-1:0]    start_index;
  logic [HANDLE_W-1:0] data_handle;

  modport source (output valid, output command, output cell_index,
                  output start_index, output data_handle, input ready);
  modport sink   (input valid, input command, input cell_index,
                  input start_index, input data_handle, output ready);
endinterface

/* rtl/psc_out_if.sv */
// ----------------------------------------------------------------------------
// psc_out_if: result channel
// Valid/ready channel that carries one command result per transfer.
// ----------------------------------------------------------------------------
interface psc_out_if;
  import psc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    chosen_cell;
  logic [HANDLE_W-1:0] handle_out;
  logic                evicted_valid;
  logic [HIT_W-1:0]    hit_count;

  modport source (output valid, output status, output chosen_cell,
                  output handle_out, output evicted_valid, output hit_count,
                  input ready);
  modport sink   (input valid, input status, input chosen_cell,
                  input handle_out, input evicted_valid, input hit_count,
                  output ready);
endinterface

/* rtl/psc_front.sv */
// ----------------------------------------------------------------------------
// psc_front: command intake and classification
// Holds the cells_in_use register, clamps it to an active count, reduces the
// scan start and checks the addressed cell, then pushes into the queue.
// ----------------------------------------------------------------------------
module psc_front #(
  parameter int ACT_MAX = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [psc_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psc_pkg::CMD_W-1:0]     in_command,
  input  logic [psc_pkg::IDX_W-1:0]     in_cell_index,
  input  logic [psc_pkg::IDX_W-1:0]     in_start_index,
  input  logic [psc_pkg::HANDLE_W-1:0]  in_data_handle,
  input  psc_pkg::psc_q_stat_t          q_stat,
  output logic                          q_push,
  output psc_pkg::psc_item_t            q_item
);
  import psc_pkg::*;

  localparam logic [CNT_W-1:0] ACT_LIMIT = CNT_W'(ACT_MAX);
  localparam int REM_W = CNT_W + IDX_W;

  logic [CNT_W-1:0] cells_in_use_r;
  logic [CNT_W-1:0] cells_in_use_nxt;
  logic [CNT_W-1:0] active;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] div_step;

  always_comb begin
    cells_in_use_nxt = cfg_we ? cfg_wdata : cells_in_use_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_in_use_r <= CFG_RESET;
    end else begin
      cells_in_use_r <= cells_in_use_nxt;
    end
  end

  // Clamp: zero acts as one, anything past the table acts as the table size
  always_comb begin
    if (cells_in_use_r == '0) begin
      active = CNT_W'(1);
    end else if (cells_in_use_r > ACT_LIMIT) begin
      active = ACT_LIMIT;
    end else begin
      active = cells_in_use_r;
    end
  end

  // Restoring remainder: the quotient fits in the start field, one bit a step
  always_comb begin
    rem      = REM_W'(in_start_index);
    div_step = '0;
    for (int i = IDX_W - 1; i >= 0; i--) begin
      div_step = REM_W'(active) << i;
      if (rem >= div_step) begin
        rem = rem - div_step;
      end
    end
  end

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.command    = in_command;
    q_item.cell_index = in_cell_index;
    q_item.start      = rem[CNT_W-1:0];
    q_item.handle     = in_data_handle;
    q_item.active     = active;
    q_item.idx_ok     = CNT_W'(in_cell_index) < active;
  end

endmodule

/* rtl/psc_queue.sv */
// ----------------------------------------------------------------------------
// psc_queue: command queue
// Short FIFO of classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
module psc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  psc_pkg::psc_item_t   wr_item,
  input  logic                 pop,
  output psc_pkg::psc_item_t   rd_item,
  output psc_pkg::psc_q_stat_t stat
);
  import psc_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  psc_item_t         entries_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_QW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item    = entries_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_QW'(QDEPTH));
  assign stat.empty = (count_r == '0);

endmodule

/* rtl/psc_back.sv */
// ----------------------------------------------------------------------------
// psc_back: command execution
// Pops one command, picks its target cell (circular free-cell find for set),
// then reads, updates and writes the cell and registers the result.
// ----------------------------------------------------------------------------
module psc_back #(
  parameter int ACT_MAX     = 16,
  parameter int MAX_READERS = 255,
  parameter int HW          = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psc_pkg::psc_q_stat_t q_stat,
  input  psc_pkg::psc_item_t   q_item,
  output logic                 q_pop,
  input  logic                 out_ready,
  output logic                 out_valid,
  output psc_pkg::psc_result_t out_result
);
  import psc_pkg::*;

  localparam int PW = $clog2(ACT_MAX);
  localparam int RW = $clog2(MAX_READERS + 1);
  localparam logic [RW-1:0] RD_MAX = RW'(MAX_READERS);

  typedef enum logic {B_IDLE, B_RUN} bstate_t;

  bstate_t     state_r, state_nxt;
  psc_item_t   item_r, item_nxt;
  logic [PW-1:0] tgt_r, tgt_nxt;
  logic        found_r, found_nxt;
  logic        out_valid_r, out_valid_nxt;
  psc_result_t result_r, result_nxt;

  logic [RW-1:0]    reader_counts_r [ACT_MAX];
  logic [HW-1:0]    cell_handles_r  [ACT_MAX];
  logic [HIT_W-1:0] cell_hits_r     [ACT_MAX];

  logic [ACT_MAX-1:0] free_vec, hi_vec;
  logic               found_hi, found_any;
  logic [PW-1:0]      first_hi, first_any;
  logic [CNT_W-1:0]   idx_ext;

  logic [RW-1:0]    cur_rc;
  logic [HW-1:0]    cur_hd;
  logic [HIT_W-1:0] cur_hits;
  logic [HW-1:0]    req_hd;
  logic             rc_we, hd_we, hits_we;
  logic [RW-1:0]    rc_val;
  logic [HIT_W-1:0] hits_val;
  logic             fire;

  // Circular find: first free cell at or after the start, else the first one
  always_comb begin
    found_hi  = 1'b0;
    found_any = 1'b0;
    first_hi  = '0;
    first_any = '0;
    for (int c = 0; c < ACT_MAX; c++) begin
      free_vec[c] = (CNT_W'(c) < q_item.active) && (reader_counts_r[c] == '0);
      hi_vec[c]   = free_vec[c] && (CNT_W'(c) >= q_item.start);
    end
    for (int c = ACT_MAX - 1; c >= 0; c--) begin
      if (hi_vec[c]) begin
        found_hi = 1'b1;
        first_hi = PW'(c);
      end
      if (free_vec[c]) begin
        found_any = 1'b1;
        first_any = PW'(c);
      end
    end
  end

  assign idx_ext  = CNT_W'(q_item.cell_index);
  assign cur_rc   = reader_counts_r[tgt_r];
  assign cur_hd   = cell_handles_r[tgt_r];
  assign cur_hits = cell_hits_r[tgt_r];
  assign req_hd   = item_r.handle[HW-1:0];
  assign fire     = (state_r == B_RUN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    tgt_nxt       = tgt_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    result_nxt    = result_r;
    q_pop         = 1'b0;
    rc_we         = 1'b0;
    hd_we         = 1'b0;
    hits_we       = 1'b0;
    rc_val        = cur_rc;
    hits_val      = cur_hits;

    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          state_nxt = B_RUN;
          if (q_item.command == CMD_SET) begin
            tgt_nxt   = found_hi ? first_hi : first_any;
            found_nxt = found_any;
          end else begin
            tgt_nxt   = idx_ext[PW-1:0];
            found_nxt = 1'b0;
          end
        end
      end
      B_RUN: begin
        if (fire) begin
          out_valid_nxt            = 1'b1;
          state_nxt                = B_IDLE;
          result_nxt.status        = ST_CONFLICT;
          result_nxt.chosen_cell   = item_r.cell_index;
          result_nxt.handle_out    = '0;
          result_nxt.evicted_valid = 1'b0;
          result_nxt.hit_count     = '0;
          case (item_r.command)
            CMD_SET: begin
              if (found_r) begin
                hd_we                    = 1'b1;
                result_nxt.status        = ST_OK;
                result_nxt.chosen_cell   = IDX_W'(CNT_W'(tgt_r));
                result_nxt.handle_out    = HANDLE_W'(cur_hd);
                result_nxt.evicted_valid = (cur_hd != '0);
              end else begin
                result_nxt.status      = ST_FULL;
                result_nxt.chosen_cell = item_r.start[IDX_W-1:0];
              end
            end
            CMD_GET: begin
              if (item_r.idx_ok && (cur_rc != RD_MAX)) begin
                rc_we    = 1'b1;
                hits_we  = 1'b1;
                rc_val   = cur_rc + RW'(1);
                hits_val = (cur_hits != '1) ? cur_hits + HIT_W'(1) : cur_hits;
                result_nxt.status     = ST_OK;
                result_nxt.handle_out = HANDLE_W'(cur_hd);
                result_nxt.hit_count  = hits_val;
              end
            end
            CMD_RELEASE: begin
              if (item_r.idx_ok && (cur_hd == req_hd) && (cur_rc != '0)) begin
                rc_we             = 1'b1;
                rc_val            = cur_rc - RW'(1);
                result_nxt.status = ST_OK;
              end
            end
            default: begin
              result_nxt.status = ST_CONFLICT;
            end
          endcase
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r   <= item_nxt;
    tgt_r    <= tgt_nxt;
    found_r  <= found_nxt;
    result_r <= result_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < ACT_MAX; c++) begin
        reader_counts_r[c] <= '0;
        cell_handles_r[c]  <= '0;
        cell_hits_r[c]     <= '0;
      end
    end else begin
      if (rc_we) begin
        reader_counts_r[tgt_r] <= rc_val;
      end
      if (hd_we) begin
        cell_handles_r[tgt_r] <= req_hd;
      end
      if (hits_we) begin
        cell_hits_r[tgt_r] <= hits_val;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

/* rtl/pinned_slot_cache_table.sv */
// ----------------------------------------------------------------------------
// pinned_slot_cache_table: reference-counted cache cell table
// Set, get and release commands on a table of pinned cache cells.
// ----------------------------------------------------------------------------
// Each command transfer on in_ch yields exactly one result transfer on out_ch,
// in order. The execution unit takes every command through two states: the
// idle state pops it from the command queue and picks the target cell (for
// set, a circular find of the first unpinned active cell from the reduced
// start index), and the run state reads, updates and writes that cell and
// loads the output register, waiting while an earlier result still stalls on
// out_ch. It finishes one command before it pops the next; out_valid comes
// from the output register. A two-entry command queue lets in_ch keep
// accepting while a result waits on out_ch. cells_in_use is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, and
// the block does not enforce it. 0 acts as one cell and values past the table
// act as its size. All cell state is cleared by reset with no extra sweep.
// ----------------------------------------------------------------------------
module pinned_slot_cache_table #(
  parameter int CELLS       = 16,
  parameter int MAX_READERS = 255,
  parameter int HANDLE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  psc_in_if.sink                    in_ch,
  psc_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [psc_pkg::CNT_W-1:0] cfg_wdata
);
  import psc_pkg::*;

  // cells_in_use tops out at 31, so cells past that are never reachable
  localparam int CFG_MAX = (1 << CNT_W) - 1;
  localparam int ACT_MAX = (CELLS < CFG_MAX) ? CELLS : CFG_MAX;
  // Handles arrive 32 bits wide; keep only the bits the table stores
  localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  psc_q_stat_t q_stat;
  psc_item_t   wr_item;
  psc_item_t   rd_item;
  psc_result_t result;
  logic        q_push;
  logic        q_pop;

  // Front: hold the config register, classify each command, push it
  psc_front #(
    .ACT_MAX (ACT_MAX)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_command     (in_ch.command),
    .in_cell_index  (in_ch.cell_index),
    .in_start_index (in_ch.start_index),
    .in_data_handle (in_ch.data_handle),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_item         (wr_item)
  );

  // Queue: decouple intake from execution
  psc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (wr_item),
    .pop     (q_pop),
    .rd_item (rd_item),
    .stat    (q_stat)
  );

  // Back: own the cell state, run one command at a time, hold the result
  psc_back #(
    .ACT_MAX     (ACT_MAX),
    .MAX_READERS (MAX_READERS),
    .HW          (HW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_item     (rd_item),
    .q_pop      (q_pop),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_result (result)
  );

  // Drive the result channel straight from the output register
  assign out_ch.status        = result.status;
  assign out_ch.chosen_cell   = result.chosen_cell;
  assign out_ch.handle_out    = result.handle_out;
  assign out_ch.evicted_valid = result.evicted_valid;
  assign out_ch.hit_count     = result.hit_count;

endmodule

/* rtl/psc_checker.sv */
// ----------------------------------------------------------------------------
// psc_checker: port-level checks for the pinned slot cache table
// Tracks commands in flight and checks result hold, capacity and failed results.
// ----------------------------------------------------------------------------
module psc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [psc_pkg::STATUS_W-1:0] status,
  input logic [psc_pkg::IDX_W-1:0]    chosen_cell,
  input logic [psc_pkg::HANDLE_W-1:0] handle_out,
  input logic                         evicted_valid,
  input logic [psc_pkg::HIT_W-1:0]    hit_count
);
  import psc_pkg::*;

  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(chosen_cell) && $stable(handle_out) &&
      $stable(evicted_valid) && $stable(hit_count))
    else $error("result changed while stalled");

  // No result without a command in flight
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("result with no command outstanding");

  // Queue, execution slot and output register all full: drop ready
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 3'd4 |-> !in_ready)
    else $error("command accepted beyond capacity");

  // Failed commands carry no handle, eviction or hit count
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> handle_out == '0 && hit_count == '0 &&
      !evicted_valid)
    else $error("failed command returned data");

endmodule

bind pinned_slot_cache_table psc_checker u_psc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .chosen_cell   (out_ch.chosen_cell),
  .handle_out    (out_ch.handle_out),
  .evicted_valid (out_ch.evicted_valid),
  .hit_count     (out_ch.hit_count)
);
